@@ rtl/core/dtma_pkg.sv @@
// Shared types, register codes, status codes and reset values for the
// dual thermocouple moving average block. No dependencies.
package dtma_pkg;

  // Ring depth default and reading range
  localparam int WINDOW_DEFAULT = 20;
  localparam int WORD_W         = 16;
  localparam int READING_W      = 12;
  localparam int READING_MAX    = 4095;

  // APB register map: register i at byte address 4*i
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [READING_W-1:0] reading_t;
  typedef logic [1:0]           reg_index_t;

  localparam reg_index_t REG_ERROR_MASK = 2'd0;
  localparam reg_index_t REG_MAX_DIFF   = 2'd1;
  localparam reg_index_t REG_OVERTEMP   = 2'd2;

  localparam word_t    ERROR_MASK_RESET = 16'h0006;
  localparam reading_t MAX_DIFF_RESET   = 12'd100;
  localparam reading_t OVERTEMP_RESET   = 12'd1200;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FAULT    = 2'd1,
    STATUS_DISAGREE = 2'd2
  } status_t;

  typedef struct packed {
    word_t    error_mask;
    reading_t max_sensor_difference;
    reading_t overtemp_limit;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
    logic push;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reject;
    logic div_done;
  } sts_t;

endpackage

@@ rtl/core/dtma_in_if.sv @@
// Request channel carrying one pair of raw converter words.
// Depends on dtma_pkg.
interface dtma_in_if;
  import dtma_pkg::*;

  logic  valid;
  logic  ready;
  word_t first_word;
  word_t second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

@@ rtl/core/dtma_out_if.sv @@
// Result channel carrying status, mean and flags for one request.
// Depends on dtma_pkg.
interface dtma_out_if;
  import dtma_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  reading_t   mean_temp;
  logic       over_temperature;
  logic       have_reading;

  modport source (output valid, output status, output mean_temp,
                  output over_temperature, output have_reading, input ready);
  modport sink   (input valid, input status, input mean_temp,
                  input over_temperature, input have_reading, output ready);
endinterface

@@ rtl/core/dtma_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module dtma_div #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int CNT_BITS = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_W - 1);

  logic                  busy;
  logic [CNT_BITS-1:0]   step;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  // Trial subtract of the held divisor from the shifted remainder
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // Control: busy and done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_BITS'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: hold the divisor, shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? DIVISOR_W'(shifted - {1'b0, dvs}) : DIVISOR_W'(shifted);
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/dtma_ctrl.sv @@
// Controller state machine: sequences input capture, checks, ring update,
// division and result hand-off. Depends on dtma_pkg.
module dtma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dtma_pkg::cmd_t cmd,
  input  dtma_pkg::sts_t sts
);
  import dtma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.reject ? S_DONE : S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready       = (state == S_IDLE);
  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised without passing through the done state");

  a_push_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> state == S_DIV)
    else $error("ring update not followed by division");

endmodule

@@ rtl/core/dtma_datapath.sv @@
// Datapath: word capture, fault and agreement checks, sample ring memory,
// running sum, serial divider and result register. Depends on dtma_pkg, dtma_div.
module dtma_datapath #(
  parameter int WINDOW = dtma_pkg::WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  dtma_pkg::cmd_t    cmd,
  output dtma_pkg::sts_t    sts,
  input  dtma_pkg::cfg_t    cfg,
  input  dtma_pkg::word_t   first_word,
  input  dtma_pkg::word_t   second_word,
  output dtma_pkg::status_t status,
  output dtma_pkg::reading_t mean_temp,
  output logic              over_temperature,
  output logic              have_reading
);
  import dtma_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(READING_MAX * WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(WINDOW);

  word_t              word_a;
  word_t              word_b;
  status_t            status_q;
  reading_t           sample_ring [WINDOW];
  reading_t           old_sample;
  logic [SLOT_W-1:0]  newest_slot;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [CNT_W-1:0]   fill_count;
  logic [SUM_W-1:0]   running_sum;
  reading_t           current_mean;
  logic               accepted_any;

  reading_t           reading_a;
  reading_t           reading_b;
  logic [READING_W:0] pair_sum;
  reading_t           sample;
  reading_t           diff;
  logic               fault;
  logic               disagree;
  status_t            eval_status;
  logic               full;
  logic [SLOT_W-1:0]  newest_inc;
  logic [SLOT_W-1:0]  oldest_inc;
  logic [SLOT_W-1:0]  write_slot;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   divisor;
  logic               div_done;
  logic [SUM_W-1:0]   quotient;

  // Extract readings and check the pair
  assign reading_a = word_a[READING_W+2:3];
  assign reading_b = word_b[READING_W+2:3];
  assign pair_sum  = {1'b0, reading_a} + {1'b0, reading_b};
  assign sample    = pair_sum[READING_W:1];
  assign diff      = (reading_a > reading_b) ? (reading_a - reading_b)
                                             : (reading_b - reading_a);
  assign fault     = (|(word_a & cfg.error_mask)) || (|(word_b & cfg.error_mask));
  assign disagree  = (diff > cfg.max_sensor_difference);

  always_comb begin
    if (fault) begin
      eval_status = STATUS_FAULT;
    end else if (disagree) begin
      eval_status = STATUS_DISAGREE;
    end else begin
      eval_status = STATUS_OK;
    end
  end

  assign sts.reject   = fault || disagree;
  assign sts.div_done = div_done;

  // Ring pointers and the next running sum
  assign full       = (fill_count == FULL_COUNT);
  assign newest_inc = (newest_slot == LAST_SLOT) ? '0 : newest_slot + SLOT_W'(1);
  assign oldest_inc = (oldest_slot == LAST_SLOT) ? '0 : oldest_slot + SLOT_W'(1);
  assign write_slot = (fill_count == '0) ? '0 : newest_inc;
  assign divisor    = full ? FULL_COUNT : fill_count + CNT_W'(1);

  always_comb begin
    if (full) begin
      sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample);
    end else if (fill_count == '0) begin
      sum_next = SUM_W'(sample);
    end else begin
      sum_next = running_sum + SUM_W'(sample);
    end
  end

  // Capture the request words and the check result
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      word_a <= first_word;
      word_b <= second_word;
    end
    if (cmd.eval) begin
      status_q <= eval_status;
    end
  end

  // Sample ring: read the oldest entry during checks, write on update
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      old_sample <= sample_ring[oldest_slot];
    end
    if (cmd.push) begin
      sample_ring[write_slot] <= sample;
    end
  end

  // Ring bookkeeping and mean
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot  <= '0;
      oldest_slot  <= '0;
      fill_count   <= '0;
      running_sum  <= '0;
      current_mean <= '0;
      accepted_any <= 1'b0;
    end else begin
      if (cmd.push) begin
        running_sum  <= sum_next;
        accepted_any <= 1'b1;
        newest_slot  <= write_slot;
        if (full) begin
          oldest_slot <= oldest_inc;
        end else begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (div_done) begin
        current_mean <= quotient[READING_W-1:0];
      end
    end
  end

  dtma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.push),
    .dividend (sum_next),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status           <= status_q;
      mean_temp        <= current_mean;
      over_temperature <= (current_mean > cfg.overtemp_limit);
      have_reading     <= accepted_any;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count beyond window");

  a_oldest_still: assert property (@(posedge clk) disable iff (rst)
    (fill_count != FULL_COUNT) |-> (oldest_slot == '0))
    else $error("oldest slot moved before the ring filled");

  a_newest_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count != '0 && fill_count != FULL_COUNT)
      |-> (newest_slot == SLOT_W'(fill_count - CNT_W'(1))))
    else $error("newest slot out of step with fill count");

endmodule

@@ rtl/core/dual_thermocouple_moving_average.sv @@
// Dual thermocouple moving average, top level: APB register file,
// controller and datapath. Depends on dtma_pkg, dtma_in_if, dtma_out_if,
// dtma_ctrl and dtma_datapath. An accepted pair passes the checks, the ring
// update and the serial divider before its result is registered; a rejected
// pair skips the ring update and the division. A new request is taken only
// once the result of the last one has been loaded into the output register.
// Reset (rst, synchronous): clears ring bookkeeping, mean and registers to
// defaults; ring contents stay undefined and need no clearing pass.
module dual_thermocouple_moving_average #(
  parameter int WINDOW = dtma_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  dtma_in_if.sink                         sample_in,
  dtma_out_if.source                      result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtma_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dtma_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dtma_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dtma_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  reg_index_t reg_index;
  logic       reg_write;
  status_t    status;

  // Register access
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_mask            <= ERROR_MASK_RESET;
      cfg.max_sensor_difference <= MAX_DIFF_RESET;
      cfg.overtemp_limit        <= OVERTEMP_RESET;
    end else if (reg_write) begin
      case (reg_index)
        REG_ERROR_MASK: cfg.error_mask            <= pwdata[WORD_W-1:0];
        REG_MAX_DIFF:   cfg.max_sensor_difference <= pwdata[READING_W-1:0];
        REG_OVERTEMP:   cfg.overtemp_limit        <= pwdata[READING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ERROR_MASK: prdata = APB_DATA_W'(cfg.error_mask);
      REG_MAX_DIFF:   prdata = APB_DATA_W'(cfg.max_sensor_difference);
      REG_OVERTEMP:   prdata = APB_DATA_W'(cfg.overtemp_limit);
      default:        prdata = '0;
    endcase
  end

  dtma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtma_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .first_word       (sample_in.first_word),
    .second_word      (sample_in.second_word),
    .status           (status),
    .mean_temp        (result_out.mean_temp),
    .over_temperature (result_out.over_temperature),
    .have_reading     (result_out.have_reading)
  );

  assign result_out.status = status;

endmodule
